@@ sv/bile_pkg.sv @@
// Shared types and constants of the bounded integer list engine.
`default_nettype none
package bile_pkg;

   localparam int unsigned DataWidth  = 32;
   localparam int unsigned OpWidth    = 3;
   localparam int unsigned StatWidth  = 2;
   localparam int unsigned PosWidth   = 7;
   localparam int unsigned ReqTdataW  = 40;
   localparam int unsigned RspTdataW  = 48;

   typedef enum logic [OpWidth-1:0] {
      OP_INS_FRONT  = 3'd0,
      OP_INS_BACK   = 3'd1,
      OP_INS_SORTED = 3'd2,
      OP_RM_FRONT   = 3'd3,
      OP_RM_BACK    = 3'd4,
      OP_RM_VALUE   = 3'd5,
      OP_SEARCH     = 3'd6,
      OP_DUMP       = 3'd7
   } op_type;

   typedef enum logic [StatWidth-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_EV,
      S_SHUP,
      S_SHUP_WR,
      S_RM_RD,
      S_RM_EV,
      S_SHDN,
      S_SHDN_WR,
      S_DUMP_RD,
      S_DUMP_EV,
      S_DUMP_OUT,
      S_RESP
   } state_type;

endpackage
`default_nettype wire

@@ sv/bounded_integer_list_engine_top.sv @@
// Top level of the bounded integer list engine: sequencer, entry memory and result register.
//
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tdata: opcode, value
//  rsp     | out | rsp_tvalid/tready    | tdata: status, position, entry_value, entry_count;
//          |     |                      | tlast: last
//
// One item at a time; req_tready is high only in the idle state.
// Each list element touched takes a read on the single memory read port:
// insert and remove shift the entries from the position onward, search scans from
// the front, dump returns one result per entry, and each result waits on rsp_tready.
// Synchronous reset empties the list; memory contents need no clearing.
// A stalled result holds the sequencer; nothing is dropped.
`default_nettype none
module bounded_integer_list_engine_top #(
   parameter int unsigned CAPACITY = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [2:0] opcode, [34:3] value, [39:35] zero
   input  wire logic [bile_pkg::ReqTdataW-1:0]      req_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [1:0] status, [8:2] position, [40:9] entry_value, [47:41] entry_count
   output logic [bile_pkg::RspTdataW-1:0]           rsp_tdata,
   output logic                                     rsp_tlast
);

   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   bile_pkg::state_type  state_ff, state_in;
   bile_pkg::op_type     op_ff, op_in;
   logic signed [bile_pkg::DataWidth-1:0] value_ff, value_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        ptr_ff, ptr_in;
   logic [CW-1:0]        idx_ff, idx_in;
   bile_pkg::status_type status_ff, status_in;
   logic [bile_pkg::PosWidth-1:0] pos_ff, pos_in;
   logic signed [bile_pkg::DataWidth-1:0] eval_ff, eval_in;
   logic                 last_ff, last_in;

   logic signed [bile_pkg::DataWidth-1:0] mem [CAPACITY];
   logic signed [bile_pkg::DataWidth-1:0] rd_data_ff;
   logic                 rd_en, wr_en;
   logic [AW-1:0]        rd_addr, wr_addr;
   logic signed [bile_pkg::DataWidth-1:0] wr_data;

   logic [CW-1:0] ptr_inc, ptr_dec;
   logic          is_full, is_empty, scan_end, shdn_end, req_hs, rsp_hs;
   bile_pkg::op_type req_op;

   assign ptr_inc  = ptr_ff + CW'(1);
   assign ptr_dec  = ptr_ff - CW'(1);
   assign is_full  = (count_ff == CW'(CAPACITY));
   assign is_empty = (count_ff == '0);
   assign scan_end = (ptr_ff == count_ff);
   assign shdn_end = (ptr_inc >= count_ff);
   assign req_op   = bile_pkg::op_type'(req_tdata[bile_pkg::OpWidth-1:0]);
   assign req_hs   = req_tvalid && req_tready;
   assign rsp_hs   = rsp_tvalid && rsp_tready;

   assign req_tready = (state_ff == bile_pkg::S_IDLE);
   assign rsp_tvalid = (state_ff == bile_pkg::S_RESP) || (state_ff == bile_pkg::S_DUMP_OUT);
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {bile_pkg::PosWidth'(count_ff), eval_ff, pos_ff, status_ff};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bile_pkg::S_IDLE: begin
            if (req_hs) begin
               case (req_op)
                  bile_pkg::OP_INS_FRONT,
                  bile_pkg::OP_INS_BACK:   state_in = is_full ? bile_pkg::S_RESP
                                                              : bile_pkg::S_SHUP;
                  bile_pkg::OP_INS_SORTED: state_in = is_full ? bile_pkg::S_RESP
                                                              : bile_pkg::S_SCAN_RD;
                  bile_pkg::OP_RM_FRONT,
                  bile_pkg::OP_RM_BACK:    state_in = is_empty ? bile_pkg::S_RESP
                                                               : bile_pkg::S_RM_RD;
                  bile_pkg::OP_RM_VALUE:   state_in = is_empty ? bile_pkg::S_RESP
                                                               : bile_pkg::S_SCAN_RD;
                  bile_pkg::OP_SEARCH:     state_in = bile_pkg::S_SCAN_RD;
                  bile_pkg::OP_DUMP:       state_in = is_empty ? bile_pkg::S_RESP
                                                               : bile_pkg::S_DUMP_RD;
                  default:                 state_in = bile_pkg::S_RESP;
               endcase
            end
         end
         bile_pkg::S_SCAN_RD: begin
            if (!scan_end) begin
               state_in = bile_pkg::S_SCAN_EV;
            end else if (op_ff == bile_pkg::OP_INS_SORTED) begin
               state_in = bile_pkg::S_SHUP;
            end else begin
               state_in = bile_pkg::S_RESP;
            end
         end
         bile_pkg::S_SCAN_EV: begin
            if (op_ff == bile_pkg::OP_INS_SORTED) begin
               state_in = (rd_data_ff < value_ff) ? bile_pkg::S_SCAN_RD : bile_pkg::S_SHUP;
            end else if (rd_data_ff == value_ff) begin
               state_in = (op_ff == bile_pkg::OP_SEARCH) ? bile_pkg::S_RESP : bile_pkg::S_SHDN;
            end else begin
               state_in = bile_pkg::S_SCAN_RD;
            end
         end
         bile_pkg::S_SHUP:     state_in = (ptr_ff == idx_ff) ? bile_pkg::S_RESP
                                                             : bile_pkg::S_SHUP_WR;
         bile_pkg::S_SHUP_WR:  state_in = bile_pkg::S_SHUP;
         bile_pkg::S_RM_RD:    state_in = bile_pkg::S_RM_EV;
         bile_pkg::S_RM_EV:    state_in = bile_pkg::S_SHDN;
         bile_pkg::S_SHDN:     state_in = shdn_end ? bile_pkg::S_RESP : bile_pkg::S_SHDN_WR;
         bile_pkg::S_SHDN_WR:  state_in = bile_pkg::S_SHDN;
         bile_pkg::S_DUMP_RD:  state_in = bile_pkg::S_DUMP_EV;
         bile_pkg::S_DUMP_EV:  state_in = bile_pkg::S_DUMP_OUT;
         bile_pkg::S_DUMP_OUT: begin
            if (rsp_hs) begin
               state_in = last_ff ? bile_pkg::S_IDLE : bile_pkg::S_DUMP_RD;
            end
         end
         bile_pkg::S_RESP:     state_in = rsp_hs ? bile_pkg::S_IDLE : bile_pkg::S_RESP;
         default:              state_in = bile_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      op_in     = op_ff;
      value_in  = value_ff;
      count_in  = count_ff;
      ptr_in    = ptr_ff;
      idx_in    = idx_ff;
      status_in = status_ff;
      pos_in    = pos_ff;
      eval_in   = eval_ff;
      last_in   = last_ff;
      rd_en     = 1'b0;
      rd_addr   = ptr_ff[AW-1:0];
      wr_en     = 1'b0;
      wr_addr   = ptr_ff[AW-1:0];
      wr_data   = rd_data_ff;
      case (state_ff)
         bile_pkg::S_IDLE: begin
            if (req_hs) begin
               op_in     = req_op;
               value_in  = req_tdata[bile_pkg::OpWidth +: bile_pkg::DataWidth];
               status_in = bile_pkg::ST_OK;
               pos_in    = '0;
               eval_in   = '0;
               last_in   = 1'b1;
               ptr_in    = '0;
               idx_in    = '0;
               case (req_op)
                  bile_pkg::OP_INS_FRONT,
                  bile_pkg::OP_INS_BACK: begin
                     ptr_in = count_ff;
                     idx_in = (req_op == bile_pkg::OP_INS_BACK) ? count_ff : '0;
                     if (is_full) begin
                        status_in = bile_pkg::ST_FULL;
                     end
                  end
                  bile_pkg::OP_INS_SORTED: begin
                     if (is_full) begin
                        status_in = bile_pkg::ST_FULL;
                     end
                  end
                  bile_pkg::OP_RM_FRONT,
                  bile_pkg::OP_RM_BACK: begin
                     idx_in = (req_op == bile_pkg::OP_RM_BACK) ? count_ff - CW'(1) : '0;
                     if (is_empty) begin
                        status_in = bile_pkg::ST_EMPTY;
                     end
                  end
                  bile_pkg::OP_RM_VALUE,
                  bile_pkg::OP_DUMP: begin
                     if (is_empty) begin
                        status_in = bile_pkg::ST_EMPTY;
                     end
                  end
                  default: ;
               endcase
            end
         end
         bile_pkg::S_SCAN_RD: begin
            if (!scan_end) begin
               rd_en = 1'b1;
            end else if (op_ff == bile_pkg::OP_INS_SORTED) begin
               idx_in = count_ff;
            end else begin
               status_in = bile_pkg::ST_NOT_FOUND;
            end
         end
         bile_pkg::S_SCAN_EV: begin
            if (op_ff == bile_pkg::OP_INS_SORTED) begin
               if (rd_data_ff < value_ff) begin
                  ptr_in = ptr_inc;
               end else begin
                  idx_in = ptr_ff;
                  ptr_in = count_ff;
               end
            end else if (rd_data_ff == value_ff) begin
               if (op_ff == bile_pkg::OP_SEARCH) begin
                  pos_in = bile_pkg::PosWidth'(ptr_inc);
               end else begin
                  eval_in = rd_data_ff;
               end
            end else begin
               ptr_in = ptr_inc;
            end
         end
         bile_pkg::S_SHUP: begin
            if (ptr_ff == idx_ff) begin
               wr_en    = 1'b1;
               wr_addr  = idx_ff[AW-1:0];
               wr_data  = value_ff;
               count_in = count_ff + CW'(1);
            end else begin
               rd_en   = 1'b1;
               rd_addr = ptr_dec[AW-1:0];
            end
         end
         bile_pkg::S_SHUP_WR: begin
            wr_en  = 1'b1;
            ptr_in = ptr_dec;
         end
         bile_pkg::S_RM_RD: begin
            rd_en   = 1'b1;
            rd_addr = idx_ff[AW-1:0];
            ptr_in  = idx_ff;
         end
         bile_pkg::S_RM_EV: eval_in = rd_data_ff;
         bile_pkg::S_SHDN: begin
            if (shdn_end) begin
               count_in = count_ff - CW'(1);
            end else begin
               rd_en   = 1'b1;
               rd_addr = ptr_inc[AW-1:0];
            end
         end
         bile_pkg::S_SHDN_WR: begin
            wr_en  = 1'b1;
            ptr_in = ptr_inc;
         end
         bile_pkg::S_DUMP_RD: rd_en = 1'b1;
         bile_pkg::S_DUMP_EV: begin
            eval_in = rd_data_ff;
            pos_in  = bile_pkg::PosWidth'(ptr_inc);
            last_in = (ptr_inc == count_ff);
         end
         bile_pkg::S_DUMP_OUT: begin
            if (rsp_hs) begin
               ptr_in = ptr_inc;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bile_pkg::S_IDLE;
         count_ff <= '0;
         last_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      value_ff  <= value_in;
      ptr_ff    <= ptr_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      pos_ff    <= pos_in;
      eval_ff   <= eval_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while a result is pending");

   a_count_idle_only: assert property (@(posedge clock) disable iff (reset)
      req_hs |=> $stable(count_ff))
      else $error("count changed right after accept");

   a_dump_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bile_pkg::S_DUMP_OUT) |->
         (last_ff == (pos_ff == bile_pkg::PosWidth'(count_ff))))
      else $error("dump last mark does not match final position");

endmodule
`default_nettype wire
